/* rtl/sge_pkg.sv */
// ----------------------------------------------------------------------------
// sge_pkg
// Shared widths, register codes and item types of the Sobel energy block.
// ----------------------------------------------------------------------------
package sge_pkg;

  localparam int unsigned PIX_W         = 24;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned GRAD_W        = 11;
  localparam int unsigned CH_ENERGY_W   = 21;
  localparam int unsigned ENERGY_W      = 23;
  localparam int unsigned FW_W          = 12;
  localparam int unsigned FH_W          = 13;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MIN_DIM       = 2;

  localparam logic [FW_W-1:0] FW_RESET     = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET     = 13'd480;
  localparam logic [FH_W-1:0] HEIGHT_LIMIT = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_DRAIN = 1'b1
  } item_mode_e;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic top_mirror;
    logic bot_mirror;
    logic left_cur;
    logic right_edge;
    logic bank;
  } item_flags_t;

  typedef struct packed {
    grad_t [NUM_CH-1:0] gx;
    grad_t [NUM_CH-1:0] gy;
    logic               last;
  } grads_t;

endpackage

/* rtl/sobel_rgb_gradient_energy.sv */
// ----------------------------------------------------------------------------
// sobel_rgb_gradient_energy
// Takes one packed RGB pixel per clock in raster order, unless in_stall_o is
// high, and returns, for every frame position, the sum over the three
// channels of the squared 3x3 Sobel X and Y gradients, with mirrored borders.
// A result belongs to the pixel that arrived W+1 beats earlier; after the last
// pixel of a frame the host sends W+1 drain beats to flush the rest, and the
// final result carries last. Both line stores are MAX_WIDTH-deep RAMs with one
// write and one read port, so a beat is taken every cycle unless the output
// stalls; a result passes the RAM read, gradient, square and channel-sum
// (output) registers in turn. Stores need no clearing after reset.
// ----------------------------------------------------------------------------
module sobel_rgb_gradient_energy import sge_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [PIX_W-1:0]      pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ENERGY_W-1:0]   energy_o,
  output logic                  last_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  item_flags_t      flags0;
  logic             take0, wr_en;
  logic [COL_W-1:0] wr_col, rd_col;
  pixel_t           rdata_a, rdata_b;
  logic             emit1;
  grads_t           grads2;

  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic s3_valid_q, s3_valid_d;
  logic out_valid_q, out_valid_d;
  logic ready1, ready2, ready3, ready4;
  logic accept, load1, adv1, adv2, adv3;

  assign ready4 = !out_valid_q || !out_stall_i;
  assign ready3 = !s3_valid_q || ready4;
  assign ready2 = !s2_valid_q || ready3;
  assign ready1 = !s1_valid_q || ready2;

  assign accept = in_valid_i && ready1;
  assign load1  = accept && take0;
  assign adv1   = s1_valid_q && ready2;
  assign adv2   = s2_valid_q && ready3;
  assign adv3   = s3_valid_q && ready4;

  assign s1_valid_d  = ready1 ? load1 : s1_valid_q;
  assign s2_valid_d  = ready2 ? (adv1 && emit1) : s2_valid_q;
  assign s3_valid_d  = ready3 ? adv2 : s3_valid_q;
  assign out_valid_d = ready4 ? adv3 : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      s3_valid_q  <= s3_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  sge_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .flags_o     (flags0),
    .take_o      (take0),
    .wr_en_o     (wr_en),
    .wr_col_o    (wr_col),
    .rd_col_o    (rd_col)
  );

  sge_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store_a (
    .clk_i   (clk_i),
    .we_i    (wr_en && !flags0.bank),
    .waddr_i (wr_col),
    .wdata_i (pixel_i),
    .re_i    (load1),
    .raddr_i (rd_col),
    .rdata_o (rdata_a)
  );

  sge_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store_b (
    .clk_i   (clk_i),
    .we_i    (wr_en && flags0.bank),
    .waddr_i (wr_col),
    .wdata_i (pixel_i),
    .re_i    (load1),
    .raddr_i (rd_col),
    .rdata_o (rdata_b)
  );

  sge_grad u_grad (
    .clk_i     (clk_i),
    .load_i    (load1),
    .flags_i   (flags0),
    .pixel_i   (pixel_i),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .step_i    (adv1),
    .emit_o    (emit1),
    .grads_o   (grads2)
  );

  sge_energy u_energy (
    .clk_i      (clk_i),
    .load_i     (adv2),
    .grads_i    (grads2),
    .out_load_i (adv3),
    .energy_o   (energy_o),
    .last_o     (last_o)
  );

  assign in_stall_o  = !ready1;
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/sge_ram.sv */
// ----------------------------------------------------------------------------
// sge_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module sge_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sge_ctrl.sv */
// ----------------------------------------------------------------------------
// sge_ctrl
// Frame registers, input and output position counters, result scheduling.
// ----------------------------------------------------------------------------
module sge_ctrl import sge_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH),
  localparam int unsigned WID_W    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned POS_W    = COL_W + ROW_W,
  localparam int unsigned POS_X    = POS_W + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic                  mode_i,
  output item_flags_t           flags_o,
  output logic                  take_o,
  output logic                  wr_en_o,
  output logic [COL_W-1:0]      wr_col_o,
  output logic [COL_W-1:0]      rd_col_o
);

  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [POS_W-1:0] pos_in_q, pos_in_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [WID_W-1:0] drain_col_q, drain_col_d;
  logic             in_done_q, in_done_d;
  logic             par_q, par_d;

  logic [WID_W-1:0] used_w, w_last;
  logic [FH_W-1:0]  used_h, h_last;
  logic             in_col_last, in_row_last, out_col_last, out_row_last;
  logic             has_in, emit, last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
      endcase
    end
  end

  // clamp the frame size to the supported range
  always_comb begin
    if (frame_width_q < FW_W'(MIN_DIM)) begin
      used_w = WID_W'(MIN_DIM);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      used_w = WID_W'(MAX_WIDTH);
    end else begin
      used_w = WID_W'(frame_width_q);
    end
    if (frame_height_q < FH_W'(MIN_DIM)) begin
      used_h = FH_W'(MIN_DIM);
    end else if (frame_height_q > HEIGHT_LIMIT) begin
      used_h = HEIGHT_LIMIT;
    end else begin
      used_h = frame_height_q;
    end
  end

  assign w_last       = used_w - 1'b1;
  assign h_last       = used_h - 1'b1;
  assign in_col_last  = WID_W'(in_col_q) == w_last;
  assign in_row_last  = FH_W'(in_row_q) == h_last;
  assign out_col_last = WID_W'(out_col_q) == w_last;
  assign out_row_last = FH_W'(out_row_q) == h_last;

  always_comb begin
    has_in = (mode_i == MODE_PIXEL) && !in_done_q;
    if (has_in) begin
      emit = (POS_X'(out_pos_q) + POS_X'(used_w) + POS_X'(1)) <= POS_X'(pos_in_q);
    end else begin
      emit = in_done_q || (out_pos_q < pos_in_q);
    end
    last = out_row_last && out_col_last;

    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    pos_in_d    = pos_in_q;
    out_pos_d   = out_pos_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    drain_col_d = drain_col_q;
    in_done_d   = in_done_q;
    par_d       = par_q;

    if (accept_i && emit) begin
      if (last) begin
        out_pos_d   = '0;
        out_row_d   = '0;
        out_col_d   = '0;
        drain_col_d = '0;
        in_done_d   = 1'b0;
        par_d       = 1'b0;
      end else begin
        out_pos_d = out_pos_q + 1'b1;
        if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
        if (in_done_q) begin
          drain_col_d = drain_col_q + 1'b1;
        end
      end
    end

    if (accept_i && has_in) begin
      if (in_col_last) begin
        in_col_d = '0;
        par_d    = !par_q;
        if (in_row_last) begin
          in_row_d  = '0;
          pos_in_d  = '0;
          in_done_d = 1'b1;
        end else begin
          in_row_d = in_row_q + 1'b1;
          pos_in_d = pos_in_q + 1'b1;
        end
      end else begin
        in_col_d = in_col_q + 1'b1;
        pos_in_d = pos_in_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      pos_in_q    <= '0;
      out_pos_q   <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      drain_col_q <= '0;
      in_done_q   <= 1'b0;
      par_q       <= 1'b0;
    end else begin
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      pos_in_q    <= pos_in_d;
      out_pos_q   <= out_pos_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      drain_col_q <= drain_col_d;
      in_done_q   <= in_done_d;
      par_q       <= par_d;
    end
  end

  assign flags_o.emit       = emit;
  assign flags_o.last       = last;
  assign flags_o.top_mirror = has_in && (in_row_q == ROW_W'(1));
  assign flags_o.bot_mirror = !has_in;
  assign flags_o.left_cur   = out_col_q == '0;
  assign flags_o.right_edge = out_col_last;
  assign flags_o.bank       = par_q;

  assign take_o   = has_in || emit;
  assign wr_en_o  = accept_i && has_in;
  assign wr_col_o = in_col_q;
  assign rd_col_o = in_done_q ? drain_col_q[COL_W-1:0] : in_col_q;

  // the closing result of a frame only ever comes after all its pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && emit && last |-> in_done_q)
    else $error("frame closed before all pixels arrived");

  // results never run ahead of the pixels of the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_done_q |-> out_pos_q <= pos_in_q)
    else $error("result position passed input position");

  // the drain column only moves once the frame input is complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_done_q |-> drain_col_q == '0)
    else $error("drain column moved during pixel input");

  // a frame end clears the done flag and the row bank on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && emit && last |=> !in_done_q && !par_q && out_pos_q == '0)
    else $error("frame end did not restart the counters");

endmodule

/* rtl/sge_grad.sv */
// ----------------------------------------------------------------------------
// sge_grad
// Column assembly with border mirroring, 3x3 window and Sobel gradients.
// ----------------------------------------------------------------------------
module sge_grad import sge_pkg::*; (
  input  logic        clk_i,
  input  logic        load_i,
  input  item_flags_t flags_i,
  input  pixel_t      pixel_i,
  input  pixel_t      rdata_a_i,
  input  pixel_t      rdata_b_i,
  input  logic        step_i,
  output logic        emit_o,
  output grads_t      grads_o
);

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  item_flags_t flags_q;
  pixel_t      pixel_q;
  column_t     col_s1_q, col_s2_q;
  column_t     col_cur, col_l, col_c, col_r;
  pixel_t      top_raw, mid_raw;
  grads_t      grads_d, grads_q;

  function automatic grad_t chan(pixel_t p, int unsigned k);
    return grad_t'(p[k*CH_W +: CH_W]);
  endfunction

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q <= flags_i;
      pixel_q <= pixel_i;
    end
  end

  // row r - 2 sits in the bank being written, row r - 1 in the other
  assign top_raw = flags_q.bank ? rdata_b_i : rdata_a_i;
  assign mid_raw = flags_q.bank ? rdata_a_i : rdata_b_i;

  always_comb begin
    col_cur.top = flags_q.top_mirror ? pixel_q : top_raw;
    col_cur.mid = mid_raw;
    col_cur.bot = flags_q.bot_mirror ? top_raw : pixel_q;
    col_l       = flags_q.left_cur ? col_cur : col_s2_q;
    col_c       = col_s1_q;
    col_r       = flags_q.right_edge ? col_s2_q : col_cur;
  end

  always_comb begin
    grad_t tl, tc, tr, ml, mr, bl, bc, br;
    grads_d.last = flags_q.last;
    for (int unsigned k = 0; k < NUM_CH; k++) begin
      tl = chan(col_l.top, k);
      tc = chan(col_c.top, k);
      tr = chan(col_r.top, k);
      ml = chan(col_l.mid, k);
      mr = chan(col_r.mid, k);
      bl = chan(col_l.bot, k);
      bc = chan(col_c.bot, k);
      br = chan(col_r.bot, k);
      grads_d.gx[k] = (tr + (mr <<< 1) + br) - (tl + (ml <<< 1) + bl);
      grads_d.gy[k] = (bl + (bc <<< 1) + br) - (tl + (tc <<< 1) + tr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      col_s2_q <= col_s1_q;
      col_s1_q <= col_cur;
      grads_q  <= grads_d;
    end
  end

  assign emit_o  = flags_q.emit;
  assign grads_o = grads_q;

endmodule

/* rtl/sge_energy.sv */
// ----------------------------------------------------------------------------
// sge_energy
// Squared gradients per channel, then the channel sum into the result register.
// ----------------------------------------------------------------------------
module sge_energy import sge_pkg::*; (
  input  logic                clk_i,
  input  logic                load_i,
  input  grads_t              grads_i,
  input  logic                out_load_i,
  output logic [ENERGY_W-1:0] energy_o,
  output logic                last_o
);

  logic [CH_ENERGY_W-1:0] ch_sum_d [NUM_CH];
  logic [CH_ENERGY_W-1:0] ch_sum_q [NUM_CH];
  logic                   last_q;
  logic [ENERGY_W-1:0]    energy_q;
  logic                   out_last_q;

  always_comb begin
    logic signed [2*GRAD_W-1:0] sqx, sqy, sum;
    for (int unsigned k = 0; k < NUM_CH; k++) begin
      sqx         = grads_i.gx[k] * grads_i.gx[k];
      sqy         = grads_i.gy[k] * grads_i.gy[k];
      sum         = sqx + sqy;
      ch_sum_d[k] = sum[CH_ENERGY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ch_sum_q <= ch_sum_d;
      last_q   <= grads_i.last;
    end
    if (out_load_i) begin
      energy_q   <= ENERGY_W'(ch_sum_q[0]) + ENERGY_W'(ch_sum_q[1]) + ENERGY_W'(ch_sum_q[2]);
      out_last_q <= last_q;
    end
  end

  assign energy_o = energy_q;
  assign last_o   = out_last_q;

endmodule
